// ===== rtl/core/bounded_ordered_list_engine_macros.svh =====
// Assertion macros used by the checker of the ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BOLE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered list engine assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BOLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered list engine assertion failed");

`endif

// ===== rtl/core/bole_pkg.sv =====
// Shared types, sizes and codes of the ordered list engine.
package bole_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OP_W     = 4;
   localparam int POS_W    = 6;
   localparam int LEN_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STAT_W   = 3;
   localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
   localparam logic [OP_W-1:0] OP_INS_AFTER = 4'd1;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 4'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 4'd3;
   localparam logic [OP_W-1:0] OP_DEL_AFTER = 4'd4;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 4'd5;
   localparam logic [OP_W-1:0] OP_READOUT   = 4'd6;
   localparam logic [OP_W-1:0] OP_COUNT     = 4'd7;
   localparam logic [OP_W-1:0] OP_SEARCH    = 4'd8;

   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_INVALID  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]          req_type;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] search_key;
   } bole_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] element;
      logic [POS_W-1:0]         found_position;
      logic [LEN_W-1:0]         length;
      logic                     last;
   } bole_rsp_type;

   // Which cell an insert or remove works on.
   typedef enum logic [1:0] {
      IDX_ZERO     = 2'd0,
      IDX_POS      = 2'd1,
      IDX_COUNT    = 2'd2,
      IDX_COUNT_M1 = 2'd3
   } bole_idx_sel_type;

   typedef struct packed {
      logic              capture;
      logic              insert;
      logic              remove;
      bole_idx_sel_type  idx_sel;
      logic              scan_next;
      logic              rsp_write;
      logic [STAT_W-1:0] rsp_status;
      logic              rsp_elem;
      logic              rsp_found;
      logic              rsp_last;
   } bole_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            empty;
      logic            full;
      logic            pos_gt_count;
      logic            pos_ge_count;
      logic            scan_match;
      logic            scan_last;
   } bole_stat_type;

endpackage

// ===== rtl/core/bole_datapath.sv =====
// Datapath of the ordered list engine: cell chain, counters and result register.
module bole_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bole_pkg::bole_req_type req_payload,
   input  bole_pkg::bole_cmd_type cmd,
   output bole_pkg::bole_stat_type stat,
   output logic                   rsp_valid,
   output bole_pkg::bole_rsp_type rsp_payload
);
   import bole_pkg::*;

   bole_req_type             req_ff;
   logic signed [DATA_W-1:0] cells_ff [CAPACITY];
   logic signed [DATA_W-1:0] cells_in [CAPACITY];
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [CNT_W-1:0]         count_m1;
   logic [IDX_W-1:0]         scan_ff;
   logic                     rsp_valid_ff;
   bole_rsp_type             rsp_ff;
   logic [IDX_W-1:0]         idx;
   logic signed [DATA_W-1:0] scan_cell;

   assign count_m1  = count_ff - CNT_W'(1);
   assign scan_cell = cells_ff[scan_ff];

   always_comb begin
      case (cmd.idx_sel)
         IDX_ZERO:     idx = '0;
         IDX_POS:      idx = req_ff.position[IDX_W-1:0];
         IDX_COUNT:    idx = count_ff[IDX_W-1:0];
         IDX_COUNT_M1: idx = count_m1[IDX_W-1:0];
         default:      idx = '0;
      endcase
   end

   // Each cell picks its neighbor, the new value or itself.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      always_comb begin
         cells_in[g] = cells_ff[g];
         if (cmd.insert) begin
            if (IDX_W'(g) == idx) begin
               cells_in[g] = req_ff.value;
            end else if (IDX_W'(g) > idx) begin
               if (g > 0) begin
                  cells_in[g] = cells_ff[(g > 0) ? g - 1 : 0];
               end
            end
         end else if (cmd.remove) begin
            if (IDX_W'(g) >= idx && g < CAPACITY - 1) begin
               cells_in[g] = cells_ff[(g < CAPACITY - 1) ? g + 1 : g];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_m1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.rsp_write) begin
         rsp_ff.status         <= cmd.rsp_status;
         rsp_ff.element        <= cmd.rsp_elem ? scan_cell : '0;
         rsp_ff.found_position <= cmd.rsp_found ? POS_W'(scan_ff) + POS_W'(1) : '0;
         rsp_ff.length         <= LEN_W'(count_in);
         rsp_ff.last           <= cmd.rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_write;
         if (cmd.capture) begin
            scan_ff <= '0;
         end else if (cmd.scan_next) begin
            scan_ff <= scan_ff + IDX_W'(1);
         end
      end
   end

   assign stat.opcode       = req_ff.req_type;
   assign stat.empty        = (count_ff == '0);
   assign stat.full         = (count_ff == CNT_W'(CAPACITY));
   assign stat.pos_gt_count = CMP_W'(req_ff.position) > CMP_W'(count_ff);
   assign stat.pos_ge_count = CMP_W'(req_ff.position) >= CMP_W'(count_ff);
   assign stat.scan_match   = (scan_cell == req_ff.search_key);
   assign stat.scan_last    = (CNT_W'(scan_ff) + CNT_W'(1) == count_ff);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/bole_controller.sv =====
// Control state machine of the ordered list engine.
module bole_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  bole_pkg::bole_stat_type stat,
   output logic                    busy,
   output bole_pkg::bole_cmd_type  cmd
);
   import bole_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_SCAN = 3'b100
   } bole_state_type;

   bole_state_type state_ff;
   bole_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.rsp_write  = 1'b1;
            cmd.rsp_last   = 1'b1;
            cmd.rsp_status = STAT_OK;
            state_in       = S_IDLE;
            case (stat.opcode)
               OP_INS_FRONT: begin
                  if (stat.full) begin
                     cmd.rsp_status = STAT_FULL;
                  end else begin
                     cmd.insert  = 1'b1;
                     cmd.idx_sel = IDX_ZERO;
                  end
               end
               OP_INS_AFTER: begin
                  if (stat.pos_gt_count) begin
                     cmd.rsp_status = STAT_INVALID;
                  end else if (stat.full) begin
                     cmd.rsp_status = STAT_FULL;
                  end else begin
                     cmd.insert  = 1'b1;
                     cmd.idx_sel = IDX_POS;
                  end
               end
               OP_INS_BACK: begin
                  if (stat.full) begin
                     cmd.rsp_status = STAT_FULL;
                  end else begin
                     cmd.insert  = 1'b1;
                     cmd.idx_sel = IDX_COUNT;
                  end
               end
               OP_DEL_FRONT: begin
                  if (stat.empty) begin
                     cmd.rsp_status = STAT_EMPTY;
                  end else begin
                     cmd.remove  = 1'b1;
                     cmd.idx_sel = IDX_ZERO;
                  end
               end
               OP_DEL_AFTER: begin
                  if (stat.empty) begin
                     cmd.rsp_status = STAT_EMPTY;
                  end else if (stat.pos_ge_count) begin
                     cmd.rsp_status = STAT_INVALID;
                  end else begin
                     cmd.remove  = 1'b1;
                     cmd.idx_sel = IDX_POS;
                  end
               end
               OP_DEL_BACK: begin
                  if (stat.empty) begin
                     cmd.rsp_status = STAT_EMPTY;
                  end else begin
                     cmd.remove  = 1'b1;
                     cmd.idx_sel = IDX_COUNT_M1;
                  end
               end
               OP_READOUT: begin
                  if (stat.empty) begin
                     cmd.rsp_status = STAT_EMPTY;
                  end else begin
                     cmd.rsp_write = 1'b0;
                     state_in      = S_SCAN;
                  end
               end
               OP_COUNT: begin
                  cmd.rsp_status = STAT_OK;
               end
               OP_SEARCH: begin
                  if (stat.empty) begin
                     cmd.rsp_status = STAT_NOTFOUND;
                  end else begin
                     cmd.rsp_write = 1'b0;
                     state_in      = S_SCAN;
                  end
               end
               default: begin
                  cmd.rsp_status = STAT_INVALID;
               end
            endcase
         end
         S_SCAN: begin
            cmd.rsp_status = STAT_OK;
            if (stat.opcode == OP_READOUT) begin
               cmd.rsp_write = 1'b1;
               cmd.rsp_elem  = 1'b1;
               cmd.rsp_last  = stat.scan_last;
               if (stat.scan_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.scan_next = 1'b1;
               end
            end else if (stat.scan_match) begin
               cmd.rsp_write = 1'b1;
               cmd.rsp_found = 1'b1;
               cmd.rsp_last  = 1'b1;
               state_in      = S_IDLE;
            end else if (stat.scan_last) begin
               cmd.rsp_write  = 1'b1;
               cmd.rsp_last   = 1'b1;
               cmd.rsp_status = STAT_NOTFOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/core/bounded_ordered_list_engine.sv =====
// Top level of the ordered list engine, an ordered list of up to 32 signed values.
// Insert, delete, count, undefined requests and an empty readout or search are worked in
// the execute state, which registers their single result; a readout of n elements gives
// one result per cycle. Other searches walk one cell per cycle and give a single result.
// A new request waits until the last one is done; the receiver cannot stall results.
// Synchronous reset empties the list and idles the controller; cell data is not cleared.
module bounded_ordered_list_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bole_pkg::bole_req_type req_payload,
   output logic                   rsp_valid,
   output bole_pkg::bole_rsp_type rsp_payload
);
   import bole_pkg::*;

   // The controller steps through the request; the datapath holds the list.
   // A transaction is taken when start is high and busy is low. Each result
   // is shown for one cycle with rsp_valid high, and the receiver cannot
   // hold it off. The next transaction is taken once the controller is idle
   // again, which is the cycle in which the final result is shown.
   bole_cmd_type  cmd;
   bole_stat_type stat;

   bole_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Inserts and deletes shift the whole cell chain in a single update; readout and
   // search read the cell at the scan index once per cycle.
   bole_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/core/bole_checker.sv =====
// Port-level checker of the ordered list engine and its binding.
`include "bounded_ordered_list_engine_macros.svh"

module bole_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input bole_pkg::bole_rsp_type rsp_payload
);
   import bole_pkg::*;

   // An accepted transaction keeps the engine busy in the next cycle.
   `BOLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

   // A result that is not the last one comes while the engine is still busy.
   `BOLE_ASSERT_NOW(a_more_busy, rsp_valid && !rsp_payload.last, busy)

   // No result appears when busy is low and was already low before.
   `BOLE_ASSERT_NOW(a_idle_quiet, !busy && !$past(busy), !rsp_valid)

   // A found position only comes with a successful final search result.
   `BOLE_ASSERT_NOW(a_found_ok, rsp_valid && rsp_payload.found_position != '0,
      rsp_payload.status == STAT_OK && rsp_payload.last)

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

// ===== bench/tb_bounded_ordered_list_engine.sv =====
// Self-checking testbench for the bounded ordered list engine.
module tb_bounded_ordered_list_engine;
   import bole_pkg::*;

   // Request type codes that the engine does not define. Every one of them must be
   // answered with a single invalid-request status and must leave the list untouched.
   localparam logic [OP_W-1:0] OP_UNDEF_FIRST = 4'd9;
   localparam logic [OP_W-1:0] OP_UNDEF_LAST  = 4'd15;

   // The watchdog ends the run after this many cycles in which neither a request nor a
   // result transaction took place. The slowest correct stretch is a full-length search
   // behind a long random sender gap, so this leaves a wide margin.
   localparam int QUIET_LIMIT     = 3000;
   // Cycles to keep watching after the last expected result. A readout of a full list
   // is the longest burst the engine can produce, so any stray result shows up in here.
   localparam int SETTLE_CYCLES   = CAPACITY + 8;
   localparam int ITEMS_PER_PHASE = 43;

   // Traffic mixes for the random part. Growing and shrinking mixes push the list to
   // its full and empty ends, where most of the special cases live.
   typedef enum logic [1:0] {
      MIX_GROW,
      MIX_BALANCED,
      MIX_SHRINK,
      MIX_FILL
   } traffic_mix_type;

   // One row of the directed table. When typed is set, the expected result is the
   // single result written in the row; otherwise the list predictor supplies it.
   typedef struct packed {
      bole_req_type      req;
      logic              typed;
      logic [STAT_W-1:0] status;
      logic [LEN_W-1:0]  length;
   } plan_row_type;

   localparam int PLAN_ROWS = 23;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   bole_req_type req_payload;
   logic         rsp_valid;
   bole_rsp_type rsp_payload;

   // Predicted contents of the list, front first, and the number of elements held.
   logic signed [DATA_W-1:0] list_cells [CAPACITY];
   int                       list_len;

   // Results still owed by the engine, oldest first, and the results of the request
   // that the predictor has just worked through.
   bole_rsp_type pending_rsps [$];
   bole_rsp_type step_rsps [$];

   int           error_count = 0;
   int           quiet_cycles;
   int           sender_idle_pct;
   plan_row_type plan [PLAN_ROWS];

   bounded_ordered_list_engine dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Every mismatch goes through here: one line on the console and one more error.
   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // Builds one result as the engine reports it: the length is always the number of
   // elements held once the request has been carried out.
   function automatic bole_rsp_type list_result(input logic [STAT_W-1:0] st,
                                                input logic [DATA_W-1:0] elem,
                                                input int found, input logic last);
      bole_rsp_type rsp;
      rsp.status         = st;
      rsp.element        = elem;
      rsp.found_position = found[POS_W-1:0];
      rsp.length         = list_len[LEN_W-1:0];
      rsp.last           = last;
      return rsp;
   endfunction

   // List predictor. It carries out one accepted request on the predicted list and
   // leaves the results the engine owes for it in step_rsps. A request that fails
   // leaves the list as it was.
   task automatic predict_list_step(input bole_req_type r);
      logic [STAT_W-1:0] st;
      int                idx;
      int                found;
      int                k;
      logic              do_insert;
      logic              do_remove;
      st        = STAT_OK;
      idx       = 0;
      found     = 0;
      do_insert = 1'b0;
      do_remove = 1'b0;
      step_rsps.delete();
      case (r.req_type)
         OP_INS_FRONT: begin
            idx       = 0;
            do_insert = 1'b1;
         end
         OP_INS_AFTER: begin
            // The position is checked before the list is tested for room.
            if (int'(r.position) > list_len) begin
               st = STAT_INVALID;
            end else begin
               idx       = int'(r.position);
               do_insert = 1'b1;
            end
         end
         OP_INS_BACK: begin
            idx       = list_len;
            do_insert = 1'b1;
         end
         OP_DEL_FRONT: begin
            if (list_len == 0) begin
               st = STAT_EMPTY;
            end else begin
               idx       = 0;
               do_remove = 1'b1;
            end
         end
         OP_DEL_AFTER: begin
            // Position p removes element p+1, so position 0 removes the front.
            if (list_len == 0) begin
               st = STAT_EMPTY;
            end else if (int'(r.position) >= list_len) begin
               st = STAT_INVALID;
            end else begin
               idx       = int'(r.position);
               do_remove = 1'b1;
            end
         end
         OP_DEL_BACK: begin
            if (list_len == 0) begin
               st = STAT_EMPTY;
            end else begin
               idx       = list_len - 1;
               do_remove = 1'b1;
            end
         end
         OP_READOUT: begin
            if (list_len == 0) begin
               st = STAT_EMPTY;
            end else begin
               for (k = 0; k < list_len; k++) begin
                  step_rsps.push_back(list_result(STAT_OK, list_cells[k], 0,
                                                  k == list_len - 1));
               end
               return;
            end
         end
         OP_COUNT: begin
         end
         OP_SEARCH: begin
            // The first match from the front wins.
            st = STAT_NOTFOUND;
            for (k = 0; k < list_len; k++) begin
               if (found == 0 && list_cells[k] == r.search_key) begin
                  st    = STAT_OK;
                  found = k + 1;
               end
            end
         end
         default: begin
            st = STAT_INVALID;
         end
      endcase
      if (do_insert) begin
         if (list_len >= CAPACITY) begin
            st = STAT_FULL;
         end else begin
            for (k = list_len; k > idx; k--) list_cells[k] = list_cells[k-1];
            list_cells[idx] = r.value;
            list_len++;
         end
      end
      if (do_remove) begin
         for (k = idx; k < list_len - 1; k++) list_cells[k] = list_cells[k+1];
         list_len--;
      end
      step_rsps.push_back(list_result(st, '0, found, 1'b1));
   endtask

   // Drives one request transaction. The sender may first sit idle for a random number
   // of cycles. The request then stays on the port until a rising edge sees busy low,
   // which is where the engine takes it and where the predictor works it through.
   // At most one assignment to start happens at each falling edge, so a request that
   // follows right behind its predecessor keeps start high without a glitch.
   task automatic issue_request(input bole_req_type r, input logic typed,
                                input logic [STAT_W-1:0] typed_status,
                                input logic [LEN_W-1:0] typed_length);
      bole_rsp_type typed_rsp;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_list_step(r);
      if (typed) begin
         typed_rsp        = '0;
         typed_rsp.status = typed_status;
         typed_rsp.length = typed_length;
         typed_rsp.last   = 1'b1;
         pending_rsps.push_back(typed_rsp);
      end else begin
         while (step_rsps.size() != 0) pending_rsps.push_back(step_rsps.pop_front());
      end
      @(negedge clock);
   endtask

   // Holds the sender back until the engine has delivered every result it owes.
   task automatic pause_until_drained();
      start <= 1'b0;
      do @(negedge clock); while (pending_rsps.size() != 0);
   endtask

   // Draws one random request for the given mix. Values are often taken from a tiny
   // range so that duplicates occur and a search has to find the first of several
   // matches. Search keys are often taken from the list itself. Positions mostly fall
   // between zero and one past the current length, where the boundaries are, and
   // otherwise anywhere in the six-bit field.
   task automatic draw_list_request(input traffic_mix_type mix, output bole_req_type r);
      int roll;
      int ins_cut;
      case (mix)
         MIX_GROW:     ins_cut = 60;
         MIX_BALANCED: ins_cut = 38;
         MIX_SHRINK:   ins_cut = 15;
         default:      ins_cut = 100;
      endcase
      roll = $urandom_range(99);
      if (roll < ins_cut) begin
         case ($urandom_range(2))
            0:       r.req_type = OP_INS_FRONT;
            1:       r.req_type = OP_INS_AFTER;
            default: r.req_type = OP_INS_BACK;
         endcase
      end else if (roll < 75) begin
         case ($urandom_range(2))
            0:       r.req_type = OP_DEL_FRONT;
            1:       r.req_type = OP_DEL_AFTER;
            default: r.req_type = OP_DEL_BACK;
         endcase
      end else if (roll < 87) begin
         r.req_type = OP_SEARCH;
      end else if (roll < 93) begin
         r.req_type = OP_READOUT;
      end else if (roll < 97) begin
         r.req_type = OP_COUNT;
      end else begin
         r.req_type = OP_W'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
      end
      if ($urandom_range(99) < 80) r.position = POS_W'($urandom_range(list_len + 1));
      else r.position = POS_W'($urandom_range(63));
      if ($urandom_range(1) == 1) r.value = $urandom;
      else r.value = $urandom_range(6) - 3;
      if (list_len > 0 && $urandom_range(99) < 50) begin
         r.search_key = list_cells[$urandom_range(list_len - 1)];
      end else if ($urandom_range(1) == 1) begin
         r.search_key = $urandom;
      end else begin
         r.search_key = $urandom_range(6) - 3;
      end
   endtask

   function automatic plan_row_type plan_row(input logic [OP_W-1:0] op, input int pos,
                                             input logic [DATA_W-1:0] val,
                                             input logic [DATA_W-1:0] key,
                                             input logic typed,
                                             input logic [STAT_W-1:0] st, input int len);
      plan_row_type p;
      p.req.req_type   = op;
      p.req.position   = pos[POS_W-1:0];
      p.req.value      = val;
      p.req.search_key = key;
      p.typed          = typed;
      p.status         = st;
      p.length         = len[LEN_W-1:0];
      return p;
   endfunction

   // Result checker. Each result transaction is compared field by field with the
   // oldest result still owed. A result that nobody is waiting for is an error too.
   always @(posedge clock) begin : check_results
      bole_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("result with nothing expected, element", rsp_payload.element,
                            '0);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", DATA_W'(rsp_payload.status), DATA_W'(want.status));
            if (rsp_payload.element !== want.element)
               report_mismatch("element", rsp_payload.element, want.element);
            if (rsp_payload.found_position !== want.found_position)
               report_mismatch("found_position", DATA_W'(rsp_payload.found_position),
                               DATA_W'(want.found_position));
            if (rsp_payload.length !== want.length)
               report_mismatch("length", DATA_W'(rsp_payload.length), DATA_W'(want.length));
            if (rsp_payload.last !== want.last)
               report_mismatch("last", DATA_W'(rsp_payload.last), DATA_W'(want.last));
         end
      end
   end

   // Watchdog: any cycle with a request or result transaction restarts the count.
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      bole_req_type    r;
      traffic_mix_type mix;
      int              row;
      int              phase;
      int              item;
      list_len        = 0;
      sender_idle_pct = 19;
      reset           = 1'b1;
      start           = 1'b0;
      req_payload     = '0;

      // Directed table. It starts on the empty list after reset, builds a short list
      // holding both extreme values, probes the insert and delete boundaries and the
      // search, and empties the list again. The readouts of a filled list and the search hit
      // are left to the predictor; every other row has its single result written in.
      plan[0]  = plan_row(OP_COUNT,     0,  '0,            '0,     1'b1, STAT_OK,       0);
      plan[1]  = plan_row(OP_READOUT,   0,  '0,            '0,     1'b1, STAT_EMPTY,    0);
      plan[2]  = plan_row(OP_DEL_FRONT, 0,  '0,            '0,     1'b1, STAT_EMPTY,    0);
      plan[3]  = plan_row(OP_DEL_BACK,  0,  '0,            '0,     1'b1, STAT_EMPTY,    0);
      plan[4]  = plan_row(OP_DEL_AFTER, 0,  '0,            '0,     1'b1, STAT_EMPTY,    0);
      plan[5]  = plan_row(OP_SEARCH,    0,  '0,            '0,     1'b1, STAT_NOTFOUND, 0);
      plan[6]  = plan_row(OP_INS_AFTER, 1,  32'h1,         '0,     1'b1, STAT_INVALID,  0);
      plan[7]  = plan_row(OP_INS_FRONT, 0,  32'h7FFF_FFFF, '0,     1'b1, STAT_OK,       1);
      plan[8]  = plan_row(OP_INS_BACK,  0,  32'h8000_0000, '0,     1'b1, STAT_OK,       2);
      plan[9]  = plan_row(OP_INS_AFTER, 0,  32'hFFFF_FFFF, '0,     1'b1, STAT_OK,       3);
      plan[10] = plan_row(OP_INS_AFTER, 3,  32'h0,         '0,     1'b1, STAT_OK,       4);
      plan[11] = plan_row(OP_INS_AFTER, 63, 32'h5,         '0,     1'b1, STAT_INVALID,  4);
      plan[12] = plan_row(OP_READOUT,   0,  '0,            '0,     1'b0, STAT_OK,       0);
      plan[13] = plan_row(OP_SEARCH,    0,  '0,  32'h8000_0000,    1'b0, STAT_OK,       0);
      plan[14] = plan_row(OP_SEARCH,    0,  '0,  32'd12345,        1'b1, STAT_NOTFOUND, 4);
      plan[15] = plan_row(OP_DEL_AFTER, 4,  '0,            '0,     1'b1, STAT_INVALID,  4);
      plan[16] = plan_row(OP_DEL_AFTER, 0,  '0,            '0,     1'b1, STAT_OK,       3);
      plan[17] = plan_row(OP_DEL_AFTER, 1,  '0,            '0,     1'b1, STAT_OK,       2);
      plan[18] = plan_row(OP_READOUT,   0,  '0,            '0,     1'b0, STAT_OK,       0);
      plan[19] = plan_row(OP_DEL_BACK,  0,  '0,            '0,     1'b1, STAT_OK,       1);
      plan[20] = plan_row(OP_DEL_FRONT, 0,  '0,            '0,     1'b1, STAT_OK,       0);
      plan[21] = plan_row(OP_UNDEF_FIRST, 0, '0,           '0,     1'b1, STAT_INVALID,  0);
      plan[22] = plan_row(OP_UNDEF_LAST, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          1'b1, STAT_INVALID, 0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < PLAN_ROWS; row++) begin
         issue_request(plan[row].req, plan[row].typed, plan[row].status, plan[row].length);
      end

      // Random part in three phases: a lightly idling sender, a heavily idling one,
      // and one that never idles. Each phase ends with the sender holding back until
      // every owed result has arrived, so the engine also gets to run dry.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       sender_idle_pct = 19;
            1:       sender_idle_pct = 75;
            default: sender_idle_pct = 0;
         endcase
         item = 0;
         if (phase == 0) begin
            // Fill the list to capacity with random inserts, then knock on the full
            // list a few times so that inserts get refused.
            while (list_len < CAPACITY) begin
               draw_list_request(MIX_FILL, r);
               issue_request(r, 1'b0, STAT_OK, '0);
               item++;
            end
            repeat (3) begin
               draw_list_request(MIX_FILL, r);
               issue_request(r, 1'b0, STAT_OK, '0);
               item++;
            end
         end
         while (item < ITEMS_PER_PHASE) begin
            mix = traffic_mix_type'((item / 12 + phase + 2) % 3);
            draw_list_request(mix, r);
            issue_request(r, 1'b0, STAT_OK, '0);
            item++;
         end
         pause_until_drained();
      end

      // Keep watching for a while so that a stray extra result is caught.
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bole_pkg.sv
rtl/core/bole_datapath.sv
rtl/core/bole_controller.sv
rtl/core/bounded_ordered_list_engine.sv
rtl/core/bole_checker.sv
bench/tb_bounded_ordered_list_engine.sv
